// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion shorthands
// concurrent checks clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

// ----- rtl/rsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// rsfe_pkg - shared types and constants
// configuration layout, result burst descriptor and segment decode
// ----------------------------------------------------------------------------
package rsfe_pkg;

	localparam int FRAME_BYTES = 4;
	localparam int CFG_IDX_W   = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIND_CODE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PATTERN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ID_LOW = 3'd6;

	// input opcodes and result kinds
	localparam logic OP_RX_BYTE  = 1'b0;
	localparam logic OP_KEY_TICK = 1'b1;
	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_SEG    = 1'b1;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] DASH_CODE   = 8'd16;
	localparam logic [7:0] ADDR_RESET  = 8'hFF;
	localparam logic [7:0] DIGIT_WRAP  = 8'd9;
	localparam logic [2:0] REPLY_LAST  = 3'd5;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] stop_code;
		logic [7:0] read_code;
		logic [7:0] write_code;
		logic [7:0] find_code;
		logic [3:0] key_pattern;
		logic [7:0] chip_id_low;
	} rsfe_cfg_t;

	// everything one item emits: optional display beat, then optional reply frame
	typedef struct packed {
		logic       load;
		logic       has_disp;
		logic [6:0] seg;
		logic       has_reply;
		logic [7:0] start_code;
		logic [7:0] addr;
		logic [7:0] func;
		logic [7:0] data;
		logic [7:0] stop_code;
	} rsfe_burst_t;

	function automatic logic [6:0] seg_of(input logic [7:0] digit);
		logic [6:0] s;
		unique case (digit)
			8'd0:    s = 7'b0111111;
			8'd1:    s = 7'b0000110;
			8'd2:    s = 7'b1011011;
			8'd3:    s = 7'b1001111;
			8'd4:    s = 7'b1100110;
			8'd5:    s = 7'b1101101;
			8'd6:    s = 7'b1111101;
			8'd7:    s = 7'b0000111;
			8'd8:    s = 7'b1111111;
			8'd9:    s = 7'b1101111;
			8'd10:   s = 7'h5F;
			8'd11:   s = 7'h7C;
			8'd12:   s = 7'h58;
			8'd13:   s = 7'h5E;
			8'd14:   s = 7'h7B;
			8'd15:   s = 7'h71;
			8'd16:   s = 7'b1000000;
			default: s = 7'b0000000;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/rsfe_core.sv -----
// ----------------------------------------------------------------------------
// rsfe_core - frame, address and key state
// updates all state for one item and describes its results
// ----------------------------------------------------------------------------
module rsfe_core
	import rsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic        opcode,
	input  logic [7:0]  rx_byte,
	input  logic        key_level,
	input  rsfe_cfg_t   cfg,
	output rsfe_burst_t burst
);

	logic       operating_q;
	logic [7:0] slave_address_q;
	logic [7:0] shown_digit_q;
	logic       in_frame_q;
	logic [7:0] frame_store_q [FRAME_BYTES];
	logic [2:0] frame_fill_q;
	logic [3:0] key_history_q;

	logic       operating_d;
	logic [7:0] slave_address_d;
	logic [7:0] shown_digit_d;
	logic       in_frame_d;
	logic       store_wr;
	logic [2:0] frame_fill_d;
	logic [3:0] key_history_d;
	logic [7:0] f_addr, f_func, f_data;
	logic       frame_ok;

	assign f_addr   = frame_store_q[0];
	assign f_func   = frame_store_q[1];
	assign f_data   = frame_store_q[2];
	assign frame_ok = ((f_addr ^ f_func ^ f_data) == frame_store_q[3]) &&
		(f_addr == slave_address_q);

	always_comb begin
		operating_d     = operating_q;
		slave_address_d = slave_address_q;
		shown_digit_d   = shown_digit_q;
		in_frame_d      = in_frame_q;
		frame_fill_d    = frame_fill_q;
		key_history_d   = key_history_q;
		store_wr        = 1'b0;
		burst           = '0;
		burst.start_code = cfg.start_code;
		burst.stop_code  = cfg.stop_code;
		burst.addr       = slave_address_q;
		if (opcode == OP_RX_BYTE) begin
			priority if (rx_byte == cfg.start_code) begin
				in_frame_d   = 1'b1;
				frame_fill_d = 3'd0;
			end else if (rx_byte == cfg.stop_code) begin
				in_frame_d = 1'b0;
				if (frame_ok) begin
					priority if (f_func == cfg.write_code) begin
						shown_digit_d   = f_data - ASCII_ZERO;
						burst.has_disp  = 1'b1;
						burst.has_reply = operating_q;
						burst.func      = cfg.write_code;
						burst.data      = ASCII_ZERO;
					end else if (f_func == cfg.read_code) begin
						burst.has_reply = operating_q;
						burst.func      = cfg.read_code;
						burst.data      = shown_digit_q + ASCII_ZERO;
					end else if (f_func == cfg.find_code) begin
						if (!operating_q) begin
							slave_address_d = cfg.chip_id_low;
							operating_d     = 1'b1;
							burst.has_reply = 1'b1;
							burst.func      = cfg.find_code;
							burst.data      = cfg.chip_id_low;
						end
					end else begin
						// unknown function: no effect
					end
				end
			end else if (in_frame_q && (frame_fill_q < 3'(FRAME_BYTES))) begin
				store_wr     = 1'b1;
				frame_fill_d = frame_fill_q + 3'd1;
			end else begin
				// stray or overrun byte
			end
		end else begin
			key_history_d = {key_history_q[2:0], key_level};
			if ((key_history_d == cfg.key_pattern) && operating_q) begin
				shown_digit_d  = (shown_digit_q >= DIGIT_WRAP) ? 8'd0 : shown_digit_q + 8'd1;
				burst.has_disp = 1'b1;
			end
		end
		burst.seg  = seg_of(shown_digit_d);
		burst.load = take && (burst.has_disp || burst.has_reply);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operating_q     <= 1'b0;
			slave_address_q <= ADDR_RESET;
			shown_digit_q   <= DASH_CODE;
			in_frame_q      <= 1'b0;
			frame_fill_q    <= 3'd0;
			key_history_q   <= 4'd0;
			for (int i = 0; i < FRAME_BYTES; i++) frame_store_q[i] <= 8'd0;
		end else if (take) begin
			operating_q     <= operating_d;
			slave_address_q <= slave_address_d;
			shown_digit_q   <= shown_digit_d;
			in_frame_q      <= in_frame_d;
			frame_fill_q    <= frame_fill_d;
			key_history_q   <= key_history_d;
			if (store_wr) frame_store_q[frame_fill_q[1:0]] <= rx_byte;
		end
	end

endmodule

// ----- rtl/rsfe_tx_seq.sv -----
// ----------------------------------------------------------------------------
// rsfe_tx_seq - result sequencer
// holds one burst and plays it out one result per accepted beat
// ----------------------------------------------------------------------------
module rsfe_tx_seq
	import rsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rsfe_burst_t burst,
	output logic        free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	logic       disp_q, rep_q;
	logic [2:0] rix_q;
	logic [6:0] seg_q;
	logic [7:0] start_q, addr_q, func_q, data_q, stop_q;
	logic [7:0] tx_byte;
	logic       beat;

	assign m_tvalid = disp_q | rep_q;
	assign m_tlast  = disp_q ? !rep_q : (rix_q == REPLY_LAST);
	assign m_tuser  = disp_q ? KIND_SEG : KIND_TX;
	assign beat     = m_tvalid & m_tready;
	assign free     = !m_tvalid | (beat & m_tlast);

	always_comb begin
		unique case (rix_q)
			3'd0:    tx_byte = start_q;
			3'd1:    tx_byte = addr_q;
			3'd2:    tx_byte = func_q;
			3'd3:    tx_byte = data_q;
			3'd4:    tx_byte = addr_q ^ func_q ^ data_q;
			default: tx_byte = stop_q;
		endcase
	end

	assign m_tdata = disp_q ? {1'b0, seg_q, 8'd0} : {8'd0, tx_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q <= 1'b0;
			rep_q  <= 1'b0;
			rix_q  <= 3'd0;
		end else if (burst.load) begin
			disp_q <= burst.has_disp;
			rep_q  <= burst.has_reply;
			rix_q  <= 3'd0;
		end else if (beat) begin
			if (disp_q) begin
				disp_q <= 1'b0;
			end else if (rix_q == REPLY_LAST) begin
				rep_q <= 1'b0;
				rix_q <= 3'd0;
			end else begin
				rix_q <= rix_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst.load) begin
			seg_q   <= burst.seg;
			start_q <= burst.start_code;
			addr_q  <= burst.addr;
			func_q  <= burst.func;
			data_q  <= burst.data;
			stop_q  <= burst.stop_code;
		end
	end

endmodule

// ----- rtl/rs485_slave_frame_engine_unit.sv -----
// ----------------------------------------------------------------------------
// rs485_slave_frame_engine_unit - rs485 slave frame engine
// bus byte framing, address check, replies, key stepping and digit display
// ----------------------------------------------------------------------------
// usage
//   s_* carries one request per item: tuser 0 = received bus byte, 1 = key tick
//   m_* returns results: tuser 0 = transmit byte, 1 = segment update; tlast marks
//   the final result of an item. items without results produce no beat
//   cfg_* writes the seven registers (index 0..6) at any time the block is idle;
//   cfg_ready is always high and unknown indexes are dropped
// timing
//   an accepted request sits in the input register until the sequencer is free;
//   then the core updates all state and loads the result sequencer, whose
//   registers drive the first result
//   requests that produce nothing flow at one per cycle while the sequencer is
//   free; an item with k results holds the sequencer for k beats (at most seven:
//   a display beat and a six-byte reply), which sets the sustained rate
// reset and stall
//   arst_n restores the register defaults, waiting mode, address 0xff and dash
//   when m_tready is low the current result holds, one more request waits in the
//   input register, and s_tready drops after that
// ----------------------------------------------------------------------------
module rs485_slave_frame_engine_unit
	import rsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [7:0] rx_byte, [8] key_level, rest zero
	input  logic                 s_tuser,   // [0] opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [7:0] tx_byte, [14:8] segments, rest zero
	output logic                 m_tuser,   // [0] kind
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	rsfe_cfg_t   cfg_q;
	rsfe_burst_t burst;

	// input register
	logic       in_valid_s1;
	logic       opcode_s1;
	logic [7:0] rx_byte_s1;
	logic       key_level_s1;

	logic seq_free;
	logic take;

	// the core works on the held request once the sequencer can take its burst
	assign take      = in_valid_s1 & seq_free;
	assign s_tready  = !in_valid_s1 | take;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1    <= s_tuser;
			rx_byte_s1   <= s_tdata[7:0];
			key_level_s1 <= s_tdata[8];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code  <= 8'd2;
			cfg_q.stop_code   <= 8'd3;
			cfg_q.read_code   <= 8'd1;
			cfg_q.write_code  <= 8'd2;
			cfg_q.find_code   <= 8'd3;
			cfg_q.key_pattern <= 4'd12;
			cfg_q.chip_id_low <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_CODE:  cfg_q.start_code  <= cfg_data;
				CFG_STOP_CODE:   cfg_q.stop_code   <= cfg_data;
				CFG_READ_CODE:   cfg_q.read_code   <= cfg_data;
				CFG_WRITE_CODE:  cfg_q.write_code  <= cfg_data;
				CFG_FIND_CODE:   cfg_q.find_code   <= cfg_data;
				CFG_KEY_PATTERN: cfg_q.key_pattern <= cfg_data[3:0];
				CFG_CHIP_ID_LOW: cfg_q.chip_id_low <= cfg_data;
				default: ;
			endcase
		end
	end

	rsfe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.opcode    (opcode_s1),
		.rx_byte   (rx_byte_s1),
		.key_level (key_level_s1),
		.cfg       (cfg_q),
		.burst     (burst)
	);

	rsfe_tx_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.burst    (burst),
		.free     (seq_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/rsfe_checker.sv -----
// ----------------------------------------------------------------------------
// rsfe_checker - port-level checks
// result format and burst continuity seen on the top-level ports
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsfe_checker
	import rsfe_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// transmit beats carry no segment bits
	`ASSERT_SAME(a_tx_no_seg, m_tvalid && (m_tuser == KIND_TX), m_tdata[15:8] == 8'd0)

	// display beats carry no byte
	`ASSERT_SAME(a_seg_no_tx, m_tvalid && (m_tuser == KIND_SEG), m_tdata[7:0] == 8'd0)

	// a burst runs without gaps until its last result
	`ASSERT_NEXT(a_burst_cont, m_tvalid && m_tready && !m_tlast, m_tvalid)

	// a stalled result holds
	`ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind rs485_slave_frame_engine_unit rsfe_checker u_rsfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - rs485 slave frame engine regression
// drives bus bytes and key ticks into the engine, predicts every transmit
// byte and display update with a behavioral copy of the engine, and checks
// each result beat in order, across several register settings and idling mixes
// ----------------------------------------------------------------------------
module tb_top;
	import rsfe_pkg::*;

	localparam int SETTLE_CYCLES = 8;    // input register, core step and margin
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_GAP       = 20;

	// segment patterns for digit codes 0..16, bit0 = segment a, code 16 is the dash
	localparam logic [16:0][6:0] SEG_ROM = {
		7'h40, 7'h71, 7'h7B, 7'h5E, 7'h58, 7'h7C, 7'h5F, 7'h6F, 7'h7F,
		7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic [6:0] segments;
		logic       last;
	} beat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // [7:0] rx_byte, [8] key_level, rest zero
	logic                 s_tuser;   // [0] opcode
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // [7:0] tx_byte, [14:8] segments, rest zero
	logic                 m_tuser;   // [0] kind
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// behavioral copy of the engine: registers and state
	rsfe_cfg_t  cfg_model;
	logic       node_operating;
	logic [7:0] node_addr;
	logic [7:0] digit;
	logic       frame_open;
	logic [7:0] frame_buf [FRAME_BYTES];
	int         frame_cnt;
	logic [3:0] key_shift;

	beat_t pending_results [$];
	int    n_errors;
	int    items_sent;
	int    idle_pct;
	int    stall_pct;
	int    hold_left;

	rs485_slave_frame_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic logic [6:0] segs_for(input logic [7:0] code);
		return (code <= DASH_CODE) ? SEG_ROM[code[4:0]] : 7'd0;
	endfunction

	task automatic push_beat(input logic kind, input logic [7:0] tx, input logic [6:0] seg,
			input logic last);
		beat_t b;
		b.kind     = kind;
		b.tx_byte  = tx;
		b.segments = seg;
		b.last     = last;
		pending_results.push_back(b);
	endtask

	// six-byte reply: start, address, function, data, xor of the three, stop
	task automatic push_reply(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] data);
		push_beat(KIND_TX, cfg_model.start_code, 7'd0, 1'b0);
		push_beat(KIND_TX, addr, 7'd0, 1'b0);
		push_beat(KIND_TX, func, 7'd0, 1'b0);
		push_beat(KIND_TX, data, 7'd0, 1'b0);
		push_beat(KIND_TX, addr ^ func ^ data, 7'd0, 1'b0);
		push_beat(KIND_TX, cfg_model.stop_code, 7'd0, 1'b1);
	endtask

	// stop byte: the stored bytes are checked, stale ones included
	task automatic close_frame;
		logic [7:0] addr;
		logic [7:0] func;
		logic [7:0] data;
		logic [7:0] old_addr;
		addr = frame_buf[0];
		func = frame_buf[1];
		data = frame_buf[2];
		if ((addr ^ func ^ data) == frame_buf[3] && addr == node_addr) begin
			// write wins over read, read over find when codes coincide
			if (func == cfg_model.write_code) begin
				digit = data - ASCII_ZERO;
				push_beat(KIND_SEG, 8'd0, segs_for(digit), !node_operating);
				if (node_operating)
					push_reply(node_addr, cfg_model.write_code, ASCII_ZERO);
			end else if (func == cfg_model.read_code) begin
				if (node_operating)
					push_reply(node_addr, cfg_model.read_code, digit + ASCII_ZERO);
			end else if (func == cfg_model.find_code && !node_operating) begin
				old_addr       = node_addr;
				node_addr      = cfg_model.chip_id_low;
				push_reply(old_addr, cfg_model.find_code, node_addr);
				node_operating = 1'b1;
			end
		end
	endtask

	task automatic predict_request(input logic op, input logic [7:0] rx, input logic lvl);
		if (op == OP_RX_BYTE) begin
			// a byte matching both codes opens a frame
			if (rx == cfg_model.start_code) begin
				frame_open = 1'b1;
				frame_cnt  = 0;
			end else if (rx == cfg_model.stop_code) begin
				frame_open = 1'b0;
				close_frame();
			end else if (frame_open && frame_cnt < FRAME_BYTES) begin
				frame_buf[2'(frame_cnt)] = rx;
				frame_cnt++;
			end
		end else begin
			// history shifts in any mode, a press only counts while operating
			key_shift = {key_shift[2:0], lvl};
			if (key_shift == cfg_model.key_pattern && node_operating) begin
				digit = (digit >= DIGIT_WRAP) ? 8'd0 : digit + 8'd1;
				push_beat(KIND_SEG, 8'd0, segs_for(digit), 1'b1);
			end
		end
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		case (idx)
			CFG_START_CODE:  cfg_model.start_code  = val;
			CFG_STOP_CODE:   cfg_model.stop_code   = val;
			CFG_READ_CODE:   cfg_model.read_code   = val;
			CFG_WRITE_CODE:  cfg_model.write_code  = val;
			CFG_FIND_CODE:   cfg_model.find_code   = val;
			CFG_KEY_PATTERN: cfg_model.key_pattern = val[3:0];
			CFG_CHIP_ID_LOW: cfg_model.chip_id_low = val;
			default: ;
		endcase
	endtask

	// result check first, then register writes and requests taken at this edge
	always @(posedge clk) begin : scoreboard
		beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: kind %0d tdata %0h last %0d",
						m_tuser, m_tdata, m_tlast);
					n_errors++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.kind) begin
						$error("kind mismatch: expected %0d actual %0d", want.kind, m_tuser);
						n_errors++;
					end
					if (m_tdata[7:0] !== want.tx_byte) begin
						$error("tx_byte mismatch: expected %0h actual %0h",
							want.tx_byte, m_tdata[7:0]);
						n_errors++;
					end
					if (m_tdata[14:8] !== want.segments) begin
						$error("segments mismatch: expected %0h actual %0h",
							want.segments, m_tdata[14:8]);
						n_errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last mismatch: expected %0d actual %0d", want.last, m_tlast);
						n_errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata[7:0], s_tdata[8]);
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls, or a long hold-off counted down here
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= !(stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------
	// one request; tvalid stays high into the next call unless a gap is drawn
	task automatic send_item(input logic op, input logic [7:0] rx, input logic lvl);
		int gap;
		gap = 0;
		while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, lvl, rx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// the unused field carries random bits, the engine must ignore it
	task automatic send_byte(input logic [7:0] rx);
		send_item(OP_RX_BYTE, rx, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_tick(input logic lvl);
		send_item(OP_KEY_TICK, 8'($urandom_range(0, 255)), lvl);
	endtask

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] data, input bit good, input int extra);
		logic [7:0] chk;
		chk = addr ^ func ^ data;
		if (!good)
			chk = chk ^ 8'($urandom_range(1, 255));
		send_byte(cfg_model.start_code);
		send_byte(addr);
		send_byte(func);
		send_byte(data);
		send_byte(chk);
		// bytes past the fourth are dropped by the engine
		repeat (extra) send_byte(8'($urandom_range(0, 255)));
		send_byte(cfg_model.stop_code);
	endtask

	// stop offering and wait for every outstanding result, plus the pipeline
	task automatic quiesce;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// all seven registers back to back, only while the engine is idle
	task automatic load_settings(input logic [7:0] start_c, input logic [7:0] stop_c,
			input logic [7:0] read_c, input logic [7:0] write_c, input logic [7:0] find_c,
			input logic [3:0] key_p, input logic [7:0] chip_id);
		cfg_write(CFG_START_CODE, start_c);
		cfg_write(CFG_STOP_CODE, stop_c);
		cfg_write(CFG_READ_CODE, read_c);
		cfg_write(CFG_WRITE_CODE, write_c);
		cfg_write(CFG_FIND_CODE, find_c);
		cfg_write(CFG_KEY_PATTERN, {4'd0, key_p});
		cfg_write(CFG_CHIP_ID_LOW, chip_id);
		cfg_valid <= 1'b0;
	endtask

	// random codes; start and stop kept apart from each other and the address
	task automatic load_random_settings;
		logic [7:0] start_c;
		logic [7:0] stop_c;
		logic [7:0] read_c;
		logic [7:0] write_c;
		logic [7:0] find_c;
		do start_c = 8'($urandom_range(0, 255)); while (start_c == node_addr);
		do stop_c = 8'($urandom_range(0, 255));
		while (stop_c == start_c || stop_c == node_addr);
		read_c  = 8'($urandom_range(0, 255));
		write_c = ($urandom_range(0, 3) == 0) ? read_c : 8'($urandom_range(0, 255));
		find_c  = ($urandom_range(0, 3) == 0) ? write_c : 8'($urandom_range(0, 255));
		load_settings(start_c, stop_c, read_c, write_c, find_c, 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic set_idling(input int sender, input int receiver);
		idle_pct  = sender;
		stall_pct <= receiver;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// register defaults: stray byte and key ticks while waiting give nothing
	task automatic test_reset_defaults;
		send_byte(8'hAA);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		quiesce();
	endtask

	// waiting mode: write shows the digit without a reply, read is ignored
	task automatic test_waiting_mode;
		send_frame(ADDR_RESET, cfg_model.write_code, 8'h33, 1'b1, 0);
		send_frame(ADDR_RESET, cfg_model.read_code, 8'h40, 1'b1, 0);
	endtask

	// discovery with an extra frame byte, then a lone stop over stale bytes
	task automatic test_discovery;
		send_frame(ADDR_RESET, cfg_model.find_code, 8'h11, 1'b1, 1);
		send_byte(cfg_model.stop_code);
		send_byte(8'h42);
	endtask

	task automatic test_operating_frames;
		send_frame(node_addr, cfg_model.read_code, 8'h77, 1'b1, 0);
		// start then stop: the stored read frame runs again
		send_byte(cfg_model.start_code);
		send_byte(cfg_model.stop_code);
		// digit code above the dash shows blank
		send_frame(node_addr, cfg_model.write_code, 8'h29, 1'b1, 0);
		// discovery while operating and a bad checksum do nothing
		send_frame(node_addr, cfg_model.find_code, 8'h00, 1'b1, 0);
		send_frame(node_addr, cfg_model.write_code, 8'h35, 1'b0, 0);
	endtask

	// press pattern all zeros: blank steps to 0, then 1, a high level breaks it
	task automatic test_key_press;
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		quiesce();
	endtask

	// start equal to stop never closes a frame; equal function codes pick write
	task automatic test_shared_codes;
		load_settings(8'h7E, 8'h7E, 8'h21, 8'h21, 8'h21, 4'hF, 8'hFF);
		send_frame(node_addr, 8'h21, 8'h35, 1'b1, 0);
		quiesce();
		load_settings(8'hFF, 8'h00, 8'h21, 8'h21, 8'h21, 4'hF, 8'hFF);
		send_frame(node_addr, 8'h21, 8'h36, 1'b1, 0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		quiesce();
	endtask

	// mostly well-formed frames and presses, with noise and broken frames
	task automatic test_random_traffic(input int n_items);
		int         first;
		int         pick;
		int         k;
		logic [7:0] func;
		logic [7:0] data;
		first = items_sent;
		while (items_sent - first < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				case ($urandom_range(0, 3))
					0: func = cfg_model.write_code;
					1: func = cfg_model.read_code;
					2: func = cfg_model.find_code;
					default: func = 8'($urandom_range(0, 255));
				endcase
				data = $urandom_range(0, 1) ? ASCII_ZERO + 8'($urandom_range(0, 20))
					: 8'($urandom_range(0, 255));
				send_frame(($urandom_range(0, 9) != 0) ? node_addr : 8'($urandom_range(0, 255)),
					func, data, $urandom_range(0, 9) != 0,
					($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			end else if (pick < 75) begin
				for (k = 3; k >= 0; k--)
					send_tick(cfg_model.key_pattern[k]);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(0, 1)));
			end else if (pick < 95) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				// short frame: the check sees stale bytes
				send_byte(cfg_model.start_code);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
				send_byte(cfg_model.stop_code);
			end
		end
		quiesce();
	endtask

	// receiver holds off while reads keep coming, so the input stalls
	task automatic test_backpressure;
		set_idling(0, 0);
		hold_left <= HOLD_CYCLES;
		repeat (4) send_frame(node_addr, cfg_model.read_code, 8'h00, 1'b1, 0);
		send_frame(node_addr, cfg_model.write_code, 8'h37, 1'b1, 0);
		quiesce();
	endtask

	task automatic finish_run;
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			n_errors++;
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		// model matches the engine after reset
		cfg_model = '{start_code: 8'h02, stop_code: 8'h03, read_code: 8'h01,
			write_code: 8'h02, find_code: 8'h03, key_pattern: 4'hC, chip_id_low: 8'h00};
		node_operating = 1'b0;
		node_addr      = ADDR_RESET;
		digit          = DASH_CODE;
		frame_open     = 1'b0;
		frame_cnt      = 0;
		key_shift      = 4'd0;
		for (int i = 0; i < FRAME_BYTES; i++)
			frame_buf[i] = 8'd0;
		n_errors   = 0;
		items_sent = 0;
		idle_pct   = 0;
		stall_pct  = 0;
		hold_left  = 0;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 16'd0;
		s_tuser   <= 1'b0;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();

		// start code at the low extreme, press pattern all zeros
		load_settings(8'h00, 8'hC3, 8'h52, 8'h57, 8'h46, 4'h0, 8'h5C);
		test_waiting_mode();
		test_discovery();
		test_operating_frames();
		test_key_press();
		test_shared_codes();

		// random phases, each under its own settings and idling mix
		set_idling(0, 0);
		test_random_traffic(17);

		load_random_settings();
		set_idling(49, 0);
		test_random_traffic(17);

		load_settings(8'h55, 8'hFF, 8'h00, 8'h7F, 8'h01, 4'h5, 8'h00);
		set_idling(0, 49);
		test_random_traffic(17);
		test_backpressure();

		load_random_settings();
		set_idling(8, 8);
		test_random_traffic(17);

		finish_run();
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rsfe_pkg.sv
rtl/rsfe_core.sv
rtl/rsfe_tx_seq.sv
rtl/rs485_slave_frame_engine_unit.sv
rtl/rsfe_checker.sv
test/tb_top.sv
